### hdl/ctr_pkg.sv
package ctr_pkg;

  localparam int unsigned TRACE_DEPTH_DEF = 32'h1000;

  // request kinds carried on the opcode field
  localparam logic REQ_EVENT = 1'b0;
  localparam logic REQ_READ  = 1'b1;

  typedef enum logic [1:0] {
    KIND_NONE   = 2'd0,
    KIND_NEW    = 2'd1,
    KIND_REPEAT = 2'd2,
    KIND_RETURN = 2'd3
  } event_kind_e;

  localparam logic [7:0] OP_CALL_NZ = 8'hC4;
  localparam logic [7:0] OP_CALL_NC = 8'hD4;
  localparam logic [7:0] OP_CALL_Z  = 8'hCC;
  localparam logic [7:0] OP_CALL_C  = 8'hDC;
  localparam logic [7:0] OP_CALL    = 8'hCD;
  localparam logic [7:0] OP_RET_NZ  = 8'hC0;
  localparam logic [7:0] OP_RET_NC  = 8'hD0;
  localparam logic [7:0] OP_RET_Z   = 8'hC8;
  localparam logic [7:0] OP_RET_C   = 8'hD8;
  localparam logic [7:0] OP_RET     = 8'hC9;
  localparam logic [7:0] OP_RETI    = 8'hD9;

  localparam logic [15:0] MAX16 = 16'hFFFF;

  function automatic logic is_call_op(input logic [7:0] op);
    logic r;
    unique case (op) inside
      OP_CALL_NZ, OP_CALL_NC, OP_CALL_Z, OP_CALL_C, OP_CALL: r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  function automatic logic is_ret_op(input logic [7:0] op);
    logic r;
    unique case (op) inside
      OP_RET_NZ, OP_RET_NC, OP_RET_Z, OP_RET_C, OP_RET, OP_RETI: r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

endpackage

### hdl/call_trace_recorder.sv
// Pipeline: a request passes the input register and then the result register before its result is valid.
// Throughput: one request per cycle unless the output stalls; the trace RAM read and write share one stage.
// Stalls propagate combinationally from out_stall_i to in_stall_o.
// Reset: rst_ni is asynchronous, active low; clears pointer, depth and valids.
// The trace RAM is not cleared; entries read before being written are undefined.
module call_trace_recorder #(
  parameter int unsigned TRACE_DEPTH = ctr_pkg::TRACE_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        opcode_i,
  input  logic [7:0]  instr_opcode_i,
  input  logic [15:0] pc_i,
  input  logic [15:0] sp_before_i,
  input  logic [15:0] sp_after_i,
  input  logic [11:0] read_index_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] entry_addr_o,
  output logic [15:0] entry_depth_o,
  output logic [15:0] entry_rep_o,
  output logic [11:0] write_position_o,
  output logic [15:0] current_depth_o,
  output logic [1:0]  event_kind_o
);
  import ctr_pkg::*;

  localparam int unsigned AW = $clog2(TRACE_DEPTH);
  localparam int unsigned XW = (AW > 12) ? AW : 12;
  localparam logic [AW-1:0] LAST_IDX = AW'(TRACE_DEPTH - 1);

  // input register
  logic        a_valid_q;
  logic        a_op_q;
  logic [7:0]  a_instr_q;
  logic [15:0] a_pc_q;
  logic [15:0] a_spb_q;
  logic [15:0] a_spa_q;
  logic [11:0] a_ridx_q;

  // tracking state
  logic [AW-1:0] ptr_q, ptr_d;
  logic [15:0]   level_q, level_d;
  logic          logged_q, logged_d;
  logic [AW-1:0] last_slot_q, last_slot_d;
  logic [15:0]   last_site_q, last_site_d;
  logic [15:0]   last_rep_q, last_rep_d;

  // result register
  logic          out_valid_q;
  logic          out_rd_ok_q;
  logic [11:0]   out_pos_q;
  logic [15:0]   out_depth_q;
  event_kind_e   out_kind_q;
  logic [15:0]   rd_site_q, rd_depth_q, rd_rep_q;

  logic [15:0] site_mem  [TRACE_DEPTH];
  logic [15:0] depth_mem [TRACE_DEPTH];
  logic [15:0] rep_mem   [TRACE_DEPTH];

  logic          b_adv, a_fire, in_fire;
  logic          is_read, call_taken, ret_taken, is_repeat, new_call;
  logic [XW-1:0] ridx_x;
  logic [AW-1:0] rd_addr;
  logic          rd_ok;
  logic [15:0]   rep_inc;
  event_kind_e   kind;

  assign b_adv      = !out_valid_q || !out_stall_i;
  assign in_stall_o = a_valid_q && !b_adv;
  assign in_fire    = in_valid_i && !in_stall_o;
  assign a_fire     = a_valid_q && b_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (!a_valid_q || b_adv) begin
      a_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      a_op_q    <= opcode_i;
      a_instr_q <= instr_opcode_i;
      a_pc_q    <= pc_i;
      a_spb_q   <= sp_before_i;
      a_spa_q   <= sp_after_i;
      a_ridx_q  <= read_index_i;
    end
  end

  // event decode
  assign is_read    = (a_op_q == REQ_READ);
  assign call_taken = !is_read && is_call_op(a_instr_q) &&
                      ({1'b0, a_spb_q} == {1'b0, a_spa_q} + 17'd2);
  assign ret_taken  = !is_read && is_ret_op(a_instr_q) &&
                      ({1'b0, a_spa_q} == {1'b0, a_spb_q} + 17'd2);
  assign is_repeat  = call_taken && logged_q && (last_site_q == a_pc_q);
  assign new_call   = call_taken && !is_repeat;
  assign rep_inc    = (last_rep_q == MAX16) ? last_rep_q : last_rep_q + 16'd1;

  assign ridx_x  = XW'(a_ridx_q);
  assign rd_ok   = ({20'd0, a_ridx_q} < 32'(TRACE_DEPTH));
  assign rd_addr = ridx_x[AW-1:0];

  always_comb begin
    ptr_d       = ptr_q;
    level_d     = level_q;
    logged_d    = logged_q;
    last_slot_d = last_slot_q;
    last_site_d = last_site_q;
    last_rep_d  = last_rep_q;
    kind        = KIND_NONE;
    if (new_call) begin
      last_slot_d = ptr_q;
      last_site_d = a_pc_q;
      last_rep_d  = 16'd1;
      logged_d    = 1'b1;
      ptr_d       = (ptr_q == LAST_IDX) ? '0 : ptr_q + AW'(1);
      kind        = KIND_NEW;
    end else if (is_repeat) begin
      last_rep_d = rep_inc;
      kind       = KIND_REPEAT;
    end else if (ret_taken) begin
      kind = KIND_RETURN;
      if (level_q != 16'd0) begin
        level_d = level_q - 16'd1;
      end
    end
    if (call_taken && level_q != MAX16) begin
      level_d = level_q + 16'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q       <= '0;
      level_q     <= '0;
      logged_q    <= 1'b0;
      last_slot_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (a_fire) begin
        ptr_q       <= ptr_d;
        level_q     <= level_d;
        logged_q    <= logged_d;
        last_slot_q <= last_slot_d;
      end
      if (b_adv) begin
        out_valid_q <= a_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_fire) begin
      last_site_q <= last_site_d;
      last_rep_q  <= last_rep_d;
      out_rd_ok_q <= is_read && rd_ok;
      out_pos_q   <= 12'(XW'(ptr_d));
      out_depth_q <= level_d;
      out_kind_q  <= kind;
    end
  end

  // trace RAM: one write and one registered read per cycle in which a request advances
  always_ff @(posedge clk_i) begin
    if (a_fire && new_call) begin
      site_mem[ptr_q]  <= a_pc_q;
      depth_mem[ptr_q] <= level_q;
    end
    if (a_fire) begin
      rd_site_q  <= site_mem[rd_addr];
      rd_depth_q <= depth_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_fire && new_call) begin
      rep_mem[ptr_q] <= 16'd1;
    end else if (a_fire && is_repeat) begin
      rep_mem[last_slot_q] <= rep_inc;
    end
    if (a_fire) begin
      rd_rep_q <= rep_mem[rd_addr];
    end
  end

  assign out_valid_o      = out_valid_q;
  assign entry_addr_o     = out_rd_ok_q ? rd_site_q  : 16'd0;
  assign entry_depth_o    = out_rd_ok_q ? rd_depth_q : 16'd0;
  assign entry_rep_o      = out_rd_ok_q ? rd_rep_q   : 16'd0;
  assign write_position_o = out_pos_q;
  assign current_depth_o  = out_depth_q;
  assign event_kind_o     = out_kind_q;

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import ctr_pkg::*;

  localparam int TRACE_LEN  = TRACE_DEPTH_DEF;
  localparam int PIPE_LAT   = 2;
  localparam int CYCLE_CAP  = 3000000;
  localparam int HOLD_LEN   = 300;
  localparam int RAND_ITEMS = 1000;
  localparam int SAT_CALLS  = 65540;

  typedef struct packed {
    logic [15:0] addr;
    logic [15:0] depth;
    logic [15:0] rep;
    logic [11:0] wpos;
    logic [15:0] level;
    event_kind_e kind;
  } trace_result_t;

  logic        clk = 1'b0;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic        opcode_i;
  logic [7:0]  instr_opcode_i;
  logic [15:0] pc_i;
  logic [15:0] sp_before_i;
  logic [15:0] sp_after_i;
  logic [11:0] read_index_i;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [15:0] entry_addr_o;
  logic [15:0] entry_depth_o;
  logic [15:0] entry_rep_o;
  logic [11:0] write_position_o;
  logic [15:0] current_depth_o;
  logic [1:0]  event_kind_o;

  call_trace_recorder uut (
    .clk_i            (clk),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .opcode_i         (opcode_i),
    .instr_opcode_i   (instr_opcode_i),
    .pc_i             (pc_i),
    .sp_before_i      (sp_before_i),
    .sp_after_i       (sp_after_i),
    .read_index_i     (read_index_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .entry_addr_o     (entry_addr_o),
    .entry_depth_o    (entry_depth_o),
    .entry_rep_o      (entry_rep_o),
    .write_position_o (write_position_o),
    .current_depth_o  (current_depth_o),
    .event_kind_o     (event_kind_o)
  );

  always #5 clk = ~clk;

  // Shadow copy of the recorder state
  logic [15:0] site_mem  [TRACE_LEN];
  logic [15:0] depth_mem [TRACE_LEN];
  logic [15:0] rep_mem   [TRACE_LEN];
  logic [11:0] ring_ptr = '0;
  logic [15:0] level    = '0;
  logic        logged   = 1'b0;
  logic [11:0] last_idx = '0;
  int          filled   = 0;

  trace_result_t trace_results_q[$];
  trace_result_t check_want;
  int unsigned   mismatches = 0;

  logic tx_idle_on = 1'b1;
  logic rx_idle_on = 1'b1;
  int   hold_token = 0;
  int   hold_seen  = 0;
  int   hold_left  = 0;

  function automatic logic is_call_byte(input logic [7:0] op);
    case (op)
      OP_CALL_NZ, OP_CALL_NC, OP_CALL_Z, OP_CALL_C, OP_CALL: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic logic is_ret_byte(input logic [7:0] op);
    case (op)
      OP_RET_NZ, OP_RET_NC, OP_RET_Z, OP_RET_C, OP_RET, OP_RETI: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic logic [7:0] call_op_at(input int i);
    case (i)
      0: return OP_CALL_NZ;
      1: return OP_CALL_NC;
      2: return OP_CALL_Z;
      3: return OP_CALL_C;
      default: return OP_CALL;
    endcase
  endfunction

  function automatic logic [7:0] ret_op_at(input int i);
    case (i)
      0: return OP_RET_NZ;
      1: return OP_RET_NC;
      2: return OP_RET_Z;
      3: return OP_RET_C;
      4: return OP_RET;
      default: return OP_RETI;
    endcase
  endfunction

  // Advance the shadow state by one request and return the result it causes
  function automatic trace_result_t step_recorder(input logic rd, input logic [7:0] iop,
                                                  input logic [15:0] pc, input logic [15:0] spb,
                                                  input logic [15:0] spa, input logic [11:0] ridx);
    trace_result_t r;
    logic [16:0] spb_wide;
    logic [16:0] spa_wide;
    r = '0;
    r.kind = KIND_NONE;
    // compare as plain integers, no 16-bit wrap
    spb_wide = {1'b0, spb};
    spa_wide = {1'b0, spa};
    if (rd == REQ_READ) begin
      if (int'(ridx) < TRACE_LEN) begin
        r.addr  = site_mem[ridx];
        r.depth = depth_mem[ridx];
        r.rep   = rep_mem[ridx];
      end
    end else if (is_call_byte(iop)) begin
      if (spb_wide == spa_wide + 17'd2) begin
        if (logged && site_mem[last_idx] == pc) begin
          if (rep_mem[last_idx] != MAX16) rep_mem[last_idx] = rep_mem[last_idx] + 16'd1;
          r.kind = KIND_REPEAT;
        end else begin
          site_mem[ring_ptr]  = pc;
          depth_mem[ring_ptr] = level;
          rep_mem[ring_ptr]   = 16'd1;
          last_idx = ring_ptr;
          logged   = 1'b1;
          ring_ptr = (int'(ring_ptr) == TRACE_LEN - 1) ? '0 : ring_ptr + 12'd1;
          if (filled < TRACE_LEN) filled++;
          r.kind = KIND_NEW;
        end
        if (level != MAX16) level = level + 16'd1;
      end
    end else if (is_ret_byte(iop)) begin
      if (spa_wide == spb_wide + 17'd2) begin
        if (level != 16'd0) level = level - 16'd1;
        r.kind = KIND_RETURN;
      end
    end
    r.wpos  = ring_ptr;
    r.level = level;
    return r;
  endfunction

  task automatic send_req(input logic rd, input logic [7:0] iop, input logic [15:0] pc,
                          input logic [15:0] spb, input logic [15:0] spa,
                          input logic [11:0] ridx);
    @(negedge clk);
    if (tx_idle_on) begin
      while ($urandom_range(0, 99) < 33) begin
        in_valid_i = 1'b0;
        @(negedge clk);
      end
    end
    in_valid_i     = 1'b1;
    opcode_i       = rd;
    instr_opcode_i = iop;
    pc_i           = pc;
    sp_before_i    = spb;
    sp_after_i     = spa;
    read_index_i   = ridx;
    @(posedge clk);
    while (in_stall_o) @(posedge clk);
    trace_results_q.push_back(step_recorder(rd, iop, pc, spb, spa, ridx));
  endtask

  task automatic send_call(input logic [15:0] pc);
    logic [15:0] spa;
    spa = 16'($urandom_range(0, 16'hFFFD));
    send_req(REQ_EVENT, call_op_at($urandom_range(0, 4)), pc, spa + 16'd2, spa,
             12'($urandom));
  endtask

  task automatic send_read();
    send_req(REQ_READ, 8'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
             12'($urandom_range(0, filled - 1)));
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_valid_i = 1'b0;
    while (trace_results_q.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed();
    // return with nothing on the call stack
    send_req(REQ_EVENT, OP_RET, 16'h0100, 16'h1000, 16'h1002, 12'h000);
    // first call lands on a site of zero
    send_req(REQ_EVENT, OP_CALL_NZ, 16'h0000, 16'hFFFF, 16'hFFFD, 12'hFFF);
    send_req(REQ_EVENT, OP_CALL_NC, 16'hFFFF, 16'h0002, 16'h0000, 12'h000);
    send_req(REQ_EVENT, OP_CALL_Z,  16'h1234, 16'hD000, 16'hCFFE, 12'hAAA);
    send_req(REQ_EVENT, OP_CALL_C,  16'h5678, 16'h8000, 16'h7FFE, 12'h555);
    send_req(REQ_EVENT, OP_CALL,    16'h5678, 16'h7FFE, 16'h7FFC, 12'h123);
    send_req(REQ_EVENT, OP_CALL,    16'h5678, 16'h7FFC, 16'h7FFA, 12'h321);
    // stack changes that are not a fall by two
    send_req(REQ_EVENT, OP_CALL, 16'h9ABC, 16'h0001, 16'hFFFF, 12'h000);
    send_req(REQ_EVENT, OP_CALL, 16'h9ABC, 16'h0000, 16'hFFFE, 12'h000);
    send_req(REQ_EVENT, OP_CALL, 16'h9ABC, 16'h1000, 16'h0FFF, 12'h000);
    send_req(REQ_EVENT, OP_CALL, 16'h9ABC, 16'h1000, 16'h1002, 12'h000);
    send_req(REQ_EVENT, OP_CALL, 16'h9ABC, 16'h1000, 16'h1000, 12'h000);
    for (int i = 0; i < 6; i++) begin
      send_req(REQ_EVENT, ret_op_at(i), 16'(16'h0200 + i), 16'hC000, 16'hC002, 12'h000);
    end
    send_req(REQ_EVENT, OP_RET, 16'h0300, 16'hFFFF, 16'h0001, 12'h000);
    send_req(REQ_EVENT, OP_RET, 16'h0300, 16'h1002, 16'h1000, 12'h000);
    send_req(REQ_EVENT, 8'h00, 16'h0400, 16'h1002, 16'h1000, 12'h000);
    send_req(REQ_EVENT, 8'hFF, 16'h0400, 16'h1000, 16'h1002, 12'hFFF);
    // reads leave the state alone even with a call pattern on the other fields
    send_req(REQ_READ, OP_CALL, 16'hFFFF, 16'h1002, 16'h1000, 12'h000);
    send_req(REQ_READ, OP_RET,  16'h0000, 16'h1000, 16'h1002, 12'h001);
    send_req(REQ_READ, 8'hFF,   16'hFFFF, 16'hFFFF, 16'hFFFF, 12'h002);
    send_req(REQ_READ, 8'h00,   16'h0000, 16'h0000, 16'h0000, 12'h003);
    drain_results();
  endtask

  task automatic test_backpressure();
    // hold the output while requests keep coming, then let the sender pause
    hold_token++;
    for (int i = 0; i < 30; i++) begin
      if (i % 3 == 0) send_call(16'($urandom));
      else if (i % 3 == 1) send_read();
      else send_req(REQ_EVENT, OP_RET, 16'($urandom), 16'h2000, 16'h2002, 12'($urandom));
    end
    drain_results();
  endtask

  task automatic test_ring_wrap();
    int n;
    logic [15:0] p;
    n = TRACE_LEN - int'(ring_ptr);
    for (int i = 0; i < n; i++) begin
      p = 16'($urandom);
      if (p == site_mem[last_idx]) p = p ^ 16'h0001;
      send_call(p);
    end
    // pointer is back at slot zero; a repeat must still find the last slot
    send_call(site_mem[last_idx]);
    send_req(REQ_READ, 8'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), 12'hFFF);
    send_req(REQ_READ, 8'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), 12'h000);
    for (int i = 0; i < 4; i++) begin
      send_call(site_mem[last_idx] ^ 16'h00F0);
      send_read();
    end
    drain_results();
  endtask

  task automatic test_random_mix();
    int sel;
    logic [15:0] spa;
    logic [15:0] spb;
    logic [15:0] delta;
    for (int i = 0; i < RAND_ITEMS; i++) begin
      tx_idle_on = !(i >= 300 && i < 500);
      rx_idle_on = tx_idle_on;
      sel = $urandom_range(0, 99);
      if (sel < 35) begin
        if (logged && $urandom_range(0, 99) < 40) send_call(site_mem[last_idx]);
        else send_call(16'($urandom));
      end else if (sel < 60) begin
        spb = 16'($urandom_range(0, 16'hFFFD));
        send_req(REQ_EVENT, ret_op_at($urandom_range(0, 5)), 16'($urandom), spb,
                 spb + 16'd2, 12'($urandom));
      end else if (sel < 80) begin
        send_read();
      end else begin
        spa   = 16'($urandom);
        delta = 16'($urandom);
        if (delta == 16'd2) delta = 16'd3;
        case ($urandom_range(0, 3))
          0: send_req(REQ_EVENT, 8'($urandom), 16'($urandom), 16'($urandom), spa,
                      12'($urandom));
          1: send_req(REQ_EVENT, call_op_at($urandom_range(0, 4)), 16'($urandom),
                      spa + delta, spa, 12'($urandom));
          2: send_req(REQ_EVENT, ret_op_at($urandom_range(0, 5)), 16'($urandom),
                      spa, spa + delta, 12'($urandom));
          default: begin
            // fall by two only modulo 2^16
            spa = 16'hFFFE + 16'($urandom_range(0, 1));
            if ($urandom_range(0, 1) == 0)
              send_req(REQ_EVENT, call_op_at($urandom_range(0, 4)), 16'($urandom),
                       spa + 16'd2, spa, 12'($urandom));
            else
              send_req(REQ_EVENT, ret_op_at($urandom_range(0, 5)), 16'($urandom),
                       spa, spa + 16'd2, 12'($urandom));
          end
        endcase
      end
    end
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    drain_results();
  endtask

  task automatic test_saturation();
    logic [15:0] p;
    // drive depth and repeat count into their upper bounds
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    p = site_mem[last_idx] ^ 16'h8000;
    for (int i = 0; i < SAT_CALLS; i++) send_call(p);
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    send_req(REQ_READ, 8'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), last_idx);
    send_req(REQ_EVENT, OP_RETI, 16'($urandom), 16'h4000, 16'h4002, 12'($urandom));
    send_call(p ^ 16'h0001);
    send_read();
  endtask

  always @(negedge clk) begin
    if (hold_token != hold_seen) begin
      hold_seen = hold_token;
      hold_left = HOLD_LEN;
    end
    if (hold_left > 0) begin
      out_stall_i = 1'b1;
      hold_left--;
    end else begin
      out_stall_i = rx_idle_on && ($urandom_range(0, 99) < 33);
    end
  end

  function automatic void check_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (trace_results_q.size() == 0) begin
        $error("result with no request outstanding");
        mismatches++;
      end else begin
        check_want = trace_results_q.pop_front();
        check_field("entry_addr", check_want.addr, entry_addr_o);
        check_field("entry_depth", check_want.depth, entry_depth_o);
        check_field("entry_rep", check_want.rep, entry_rep_o);
        check_field("write_position", 16'(check_want.wpos), 16'(write_position_o));
        check_field("current_depth", check_want.level, current_depth_o);
        check_field("event_kind", 16'(check_want.kind), 16'(event_kind_o));
      end
    end
  end

  initial begin
    repeat (CYCLE_CAP) @(posedge clk);
    $display("call_trace_recorder: mismatch");
    $finish;
  end

  initial begin
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    opcode_i       = REQ_EVENT;
    instr_opcode_i = '0;
    pc_i           = '0;
    sp_before_i    = '0;
    sp_after_i     = '0;
    read_index_i   = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_ni = 1'b1;

    test_directed();
    test_backpressure();
    test_ring_wrap();
    test_random_mix();
    test_saturation();

    drain_results();
    repeat (PIPE_LAT + 4) @(posedge clk);
    if (mismatches == 0) begin
      $display("call_trace_recorder: match");
    end else begin
      $display("call_trace_recorder: mismatch");
    end
    $finish;
  end

endmodule

### files.f
hdl/ctr_pkg.sv
hdl/call_trace_recorder.sv
tb/testbench.sv
